@@ hw/rtl/e2q_pkg.sv @@
// e2q_pkg: shared constants, types and arithmetic helpers for the
// Euler-to-quaternion unit. No dependencies.
package e2q_pkg;

   localparam int TRIG_ITERATIONS = 24;
   localparam int CORDIC_STAGES   = (TRIG_ITERATIONS > 32) ? 32 : TRIG_ITERATIONS;
   // degree path: offset, reciprocal multiply, remainder; radian path delayed to match
   localparam int PHASE_STAGES    = 3;
   localparam int LANE_LAT        = 4 + PHASE_STAGES + CORDIC_STAGES;
   localparam int NUM_LANES       = 3;

   localparam logic [5:0]  DEG_DIVISOR     = 6'd45;
   localparam int          DEG_SHIFT       = 38;
   localparam logic [32:0] DEG_RECIP       =
      33'(((64'd1 << DEG_SHIFT) / 64'(DEG_DIVISOR)) + 64'd1);
   // 2^31 + DEG_OFFSET = DEG_DIVISOR * DEG_BIAS
   localparam logic [32:0] DEG_OFFSET      = 33'd7;
   localparam logic [27:0] DEG_BIAS        = 28'd47721859;
   localparam logic [14:0] DEG_FRAC_RECIP  =
      15'(((64'd1 << 20) / 64'(DEG_DIVISOR)) + 64'd1);
   localparam logic [31:0] TWO_OVER_PI_Q32 = 32'hA2F9836E;
   localparam logic [33:0] CORDIC_INV_GAIN = 34'h026DD3B6A;

   typedef logic signed [33:0] trig_type;

   function automatic logic [31:0] atan_turn(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;
         5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

   // floor(256 * r / 45) for a remainder r below 45
   function automatic logic [7:0] deg_frac(input logic [5:0] r);
      logic [20:0] p;
      p = 21'(r) * 21'(DEG_FRAC_RECIP);
      return p[19:12];
   endfunction

   // Q1.30 product, round half up, arithmetic shift
   function automatic trig_type mulq(input trig_type a, input trig_type b);
      logic signed [67:0] p;
      p = a * b;
      p = p + (68'sd1 <<< 29);
      return p[63:30];
   endfunction

   function automatic logic [31:0] sat32(input logic signed [34:0] v);
      logic [31:0] r;
      if (v > 35'sh07FFFFFFF)
         r = 32'h7FFFFFFF;
      else if (v < -35'sh080000000)
         r = 32'h80000000;
      else
         r = v[31:0];
      return r;
   endfunction

endpackage

@@ hw/rtl/e2q_lane.sv @@
// e2q_lane: one angle lane: half-angle phase (radian multiply or degree
// reciprocal division by 45) and a pipelined CORDIC giving cosine and sine. Uses e2q_pkg.
module e2q_lane import e2q_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic        degree_mode,
   input  logic [31:0] angle,
   output logic        valid,
   output trig_type    cos_out,
   output trig_type    sin_out
);

   logic [LANE_LAT-1:0] valid_ff, valid_in;
   logic signed [31:0]  ang_ff;
   logic signed [64:0]  rad_prod;
   logic [31:0]         rad_ff  [PHASE_STAGES+1];
   logic [32:0]         deg_b_in, deg_b_ff, deg_b2_ff, deg_mul;
   logic [65:0]         deg_prod_ff;
   logic [27:0]         deg_q;
   logic [23:0]         deg_hi_ff;
   logic [5:0]          deg_rem_ff;
   logic [31:0]         deg_phase_ff;
   logic [31:0]         phase;
   trig_type            x_ff    [CORDIC_STAGES+1];
   trig_type            y_ff    [CORDIC_STAGES+1];
   logic signed [32:0]  z_ff    [CORDIC_STAGES+1];
   logic [1:0]          quad_ff [CORDIC_STAGES+1];
   trig_type            cos_ff, sin_ff;

   assign valid_in = {valid_ff[LANE_LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ang_ff <= angle;
      end
   end

   assign rad_prod = ang_ff * $signed({1'b0, TWO_OVER_PI_Q32});
   // angle + 2^31 + 7, always positive
   assign deg_b_in = 33'({~ang_ff[31], ang_ff[30:0]}) + DEG_OFFSET;
   assign deg_q    = deg_prod_ff[DEG_SHIFT+27:DEG_SHIFT];
   assign deg_mul  = 33'(deg_q) * 33'(DEG_DIVISOR);

   always_ff @(posedge clock) begin
      rad_ff[0]    <= rad_prod[54:23];
      deg_b_ff     <= deg_b_in;
      deg_prod_ff  <= deg_b_ff * DEG_RECIP;
      deg_b2_ff    <= deg_b_ff;
      deg_hi_ff    <= 24'(deg_q - DEG_BIAS);
      deg_rem_ff   <= 6'(deg_b2_ff - deg_mul);
      deg_phase_ff <= {deg_hi_ff, deg_frac(deg_rem_ff)};
   end

   for (genvar k = 0; k < PHASE_STAGES; k++) begin : g_rad
      always_ff @(posedge clock) begin
         rad_ff[k+1] <= rad_ff[k];
      end
   end

   assign phase = degree_mode ? deg_phase_ff : rad_ff[PHASE_STAGES];

   always_ff @(posedge clock) begin
      x_ff[0]    <= CORDIC_INV_GAIN;
      y_ff[0]    <= '0;
      z_ff[0]    <= $signed({3'b000, phase[29:0]});
      quad_ff[0] <= phase[31:30];
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (!z_ff[i][32]) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - $signed({1'b0, atan_turn(5'(i))});
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + $signed({1'b0, atan_turn(5'(i))});
         end
         quad_ff[i+1] <= quad_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      case (quad_ff[CORDIC_STAGES])
         2'd0: begin
            cos_ff <= x_ff[CORDIC_STAGES];
            sin_ff <= y_ff[CORDIC_STAGES];
         end
         2'd1: begin
            cos_ff <= -y_ff[CORDIC_STAGES];
            sin_ff <= x_ff[CORDIC_STAGES];
         end
         2'd2: begin
            cos_ff <= -x_ff[CORDIC_STAGES];
            sin_ff <= -y_ff[CORDIC_STAGES];
         end
         default: begin
            cos_ff <= y_ff[CORDIC_STAGES];
            sin_ff <= -x_ff[CORDIC_STAGES];
         end
      endcase
   end

   assign valid   = valid_ff[LANE_LAT-1];
   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

@@ hw/rtl/e2q_merge.sv @@
// e2q_merge: combines the three lanes' cosines and sines into the quaternion
// through pair products, triple products and saturating sums. Uses e2q_pkg.
module e2q_merge import e2q_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        valid,
   input  trig_type    cos_in [NUM_LANES],
   input  trig_type    sin_in [NUM_LANES],
   output logic        rsp_valid,
   output logic [31:0] rsp_quat_x,
   output logic [31:0] rsp_quat_y,
   output logic [31:0] rsp_quat_z,
   output logic [31:0] rsp_quat_w
);

   logic [2:0]  valid_ff;
   trig_type    s1c2_ff, c1s2_ff, c1c2_ff, s1s2_ff, c3_ff, s3_ff;
   trig_type    t_xa_ff, t_xb_ff, t_ya_ff, t_yb_ff, t_za_ff, t_zb_ff, t_wa_ff, t_wb_ff;
   logic [31:0] qx_ff, qy_ff, qz_ff, qw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[1:0], valid};
      end
   end

   always_ff @(posedge clock) begin
      s1c2_ff <= mulq(sin_in[0], cos_in[1]);
      c1s2_ff <= mulq(cos_in[0], sin_in[1]);
      c1c2_ff <= mulq(cos_in[0], cos_in[1]);
      s1s2_ff <= mulq(sin_in[0], sin_in[1]);
      c3_ff   <= cos_in[2];
      s3_ff   <= sin_in[2];
   end

   always_ff @(posedge clock) begin
      t_xa_ff <= mulq(s1c2_ff, c3_ff);
      t_xb_ff <= mulq(c1s2_ff, s3_ff);
      t_ya_ff <= mulq(c1s2_ff, c3_ff);
      t_yb_ff <= mulq(s1c2_ff, s3_ff);
      t_za_ff <= mulq(c1c2_ff, s3_ff);
      t_zb_ff <= mulq(s1s2_ff, c3_ff);
      t_wa_ff <= mulq(c1c2_ff, c3_ff);
      t_wb_ff <= mulq(s1s2_ff, s3_ff);
   end

   always_ff @(posedge clock) begin
      qx_ff <= sat32(35'(t_xa_ff) - 35'(t_xb_ff));
      qy_ff <= sat32(35'(t_ya_ff) + 35'(t_yb_ff));
      qz_ff <= sat32(35'(t_za_ff) - 35'(t_zb_ff));
      qw_ff <= sat32(35'(t_wa_ff) + 35'(t_wb_ff));
   end

   assign rsp_valid  = valid_ff[2];
   assign rsp_quat_x = qx_ff;
   assign rsp_quat_y = qy_ff;
   assign rsp_quat_z = qz_ff;
   assign rsp_quat_w = qw_ff;

endmodule

@@ hw/rtl/euler_to_quaternion_unit.sv @@
// euler_to_quaternion_unit: top level; three e2q_lane instances (roll, pitch,
// yaw) and an e2q_merge stage. Uses e2q_pkg.
//
// Fully pipelined: busy stays low and a request may be issued every cycle.
// Each request yields one rsp_valid pulse after passing through the
// three-stage reciprocal divide-by-45 phase path, one register per CORDIC
// iteration and the three merge stages. Results cannot be held off; capture
// them on the strobe. Write csr_wr_data (degree mode) only while no request
// is in flight.
module euler_to_quaternion_unit import e2q_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_roll_angle,
   input  logic [31:0] req_pitch_angle,
   input  logic [31:0] req_yaw_angle,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   output logic        rsp_valid,
   output logic [31:0] rsp_quat_x,
   output logic [31:0] rsp_quat_y,
   output logic [31:0] rsp_quat_z,
   output logic [31:0] rsp_quat_w
);

   logic        degree_mode_ff, degree_mode_in;
   logic        accept;
   logic [31:0] angle_w [NUM_LANES];
   logic        lane_valid [NUM_LANES];
   trig_type    cos_w [NUM_LANES];
   trig_type    sin_w [NUM_LANES];

   assign busy           = 1'b0;
   assign accept         = start & ~busy;
   assign degree_mode_in = csr_wr_en ? csr_wr_data : degree_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_mode_ff <= 1'b0;
      end else begin
         degree_mode_ff <= degree_mode_in;
      end
   end

   assign angle_w[0] = req_roll_angle;
   assign angle_w[1] = req_pitch_angle;
   assign angle_w[2] = req_yaw_angle;

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      e2q_lane u_lane (
         .clock       (clock),
         .reset       (reset),
         .accept      (accept),
         .degree_mode (degree_mode_ff),
         .angle       (angle_w[l]),
         .valid       (lane_valid[l]),
         .cos_out     (cos_w[l]),
         .sin_out     (sin_w[l])
      );
   end

   e2q_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .valid      (lane_valid[0]),
      .cos_in     (cos_w),
      .sin_in     (sin_w),
      .rsp_valid  (rsp_valid),
      .rsp_quat_x (rsp_quat_x),
      .rsp_quat_y (rsp_quat_y),
      .rsp_quat_z (rsp_quat_z),
      .rsp_quat_w (rsp_quat_w)
   );

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      (lane_valid[0] == lane_valid[1]) && (lane_valid[0] == lane_valid[2]))
      else $error("lane valid pipelines out of step");

   a_valid_cleared: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe after reset");

   a_rsp_follows_lane: assert property (@(posedge clock) disable iff (reset)
      lane_valid[0] |-> ##3 rsp_valid)
      else $error("lane output lost in merge");

endmodule

@@ tb/euler_to_quaternion_unit_checker.sv @@
// Checker for euler_to_quaternion_unit: watches accepted requests and result
// strobes, predicts each quaternion, compares in order. Uses e2q_pkg only for the CORDIC iteration count.
`timescale 1ns / 100ps

module euler_to_quaternion_unit_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [31:0] req_roll_angle,
   input  logic [31:0] req_pitch_angle,
   input  logic [31:0] req_yaw_angle,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        rsp_valid,
   input  logic [31:0] rsp_quat_x,
   input  logic [31:0] rsp_quat_y,
   input  logic [31:0] rsp_quat_z,
   input  logic [31:0] rsp_quat_w,
   output int          error_count,
   output int          pending_count,
   output int          result_count
);

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] w;
   } quat_type;

   localparam int ROT_STEPS = (e2q_pkg::TRIG_ITERATIONS > 32) ? 32 : e2q_pkg::TRIG_ITERATIONS;
   localparam longint INV_GAIN = 64'h26DD3B6A;

   logic [31:0] rot_angle [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};

   logic     deg_mode;
   quat_type expected_quats [$];

   function automatic logic [31:0] half_turn_phase(logic [31:0] a, logic deg);
      longint sa, n;
      logic [63:0] p;
      sa = longint'($signed(a));
      if (deg) begin
         n = sa * 256 + 45 * (64'sd1 <<< 40);
         return 32'(n / 45);
      end
      p = 64'(sa) * 64'hA2F9836E;
      return p[54:23];
   endfunction

   function automatic void rotate(logic [31:0] ph, output longint c, output longint s);
      longint x, y, z, dx, dy;
      x = INV_GAIN;
      y = 0;
      z = longint'(ph[29:0]);
      for (int i = 0; i < ROT_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(rot_angle[i]);
         end else begin
            x += dx; y -= dy; z += longint'(rot_angle[i]);
         end
      end
      case (ph[31:30])
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function automatic longint qmul(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic logic [31:0] clamp32(longint v);
      if (v > 64'sh7FFFFFFF) return 32'h7FFFFFFF;
      if (v < -64'sh80000000) return 32'h80000000;
      return v[31:0];
   endfunction

   function automatic quat_type predict_quat(logic [31:0] r, logic [31:0] p,
                                             logic [31:0] yw, logic deg);
      longint c1, s1, c2, s2, c3, s3;
      quat_type q;
      rotate(half_turn_phase(r, deg), c1, s1);
      rotate(half_turn_phase(p, deg), c2, s2);
      rotate(half_turn_phase(yw, deg), c3, s3);
      q.x = clamp32(qmul(qmul(s1, c2), c3) - qmul(qmul(c1, s2), s3));
      q.y = clamp32(qmul(qmul(c1, s2), c3) + qmul(qmul(s1, c2), s3));
      q.z = clamp32(qmul(qmul(c1, c2), s3) - qmul(qmul(s1, s2), c3));
      q.w = clamp32(qmul(qmul(c1, c2), c3) + qmul(qmul(s1, s2), s3));
      return q;
   endfunction

   assign pending_count = expected_quats.size();

   always @(posedge clock) begin
      quat_type e, a;
      if (reset) begin
         deg_mode <= 1'b0;
         error_count <= 0;
         result_count <= 0;
         expected_quats.delete();
      end else begin
         if (rsp_valid) begin
            a = '{rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w};
            result_count <= result_count + 1;
            if (expected_quats.size() == 0) begin
               if (error_count < 10)
                  $display("unexpected result %h", a);
               error_count <= error_count + 1;
            end else begin
               e = expected_quats.pop_front();
               if (e !== a) begin
                  if (error_count < 10)
                     $display("mismatch: expected x=%h y=%h z=%h w=%h, got x=%h y=%h z=%h w=%h",
                              e.x, e.y, e.z, e.w, a.x, a.y, a.z, a.w);
                  error_count <= error_count + 1;
               end
            end
         end
         if (start && !busy)
            expected_quats.push_back(predict_quat(req_roll_angle, req_pitch_angle,
                                                  req_yaw_angle, deg_mode));
         if (csr_wr_en)
            deg_mode <= csr_wr_data;
      end
   end

endmodule

@@ tb/euler_to_quaternion_unit_test.sv @@
// Top of the euler_to_quaternion_unit testbench: clock, reset, request
// stimulus and verdict. Depends on the unit, e2q_pkg and the checker.
`timescale 1ns / 100ps

module euler_to_quaternion_unit_test;

   logic        clock = 0, reset = 1, start = 0, csr_wr_en = 0, csr_wr_data = 0;
   logic [31:0] req_roll_angle = 0, req_pitch_angle = 0, req_yaw_angle = 0;
   logic        busy, rsp_valid;
   logic [31:0] rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w;
   int          error_count, pending_count, result_count;
   int          request_count = 0;

   euler_to_quaternion_unit DUT (.*);
   euler_to_quaternion_unit_checker checker_i (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("euler_to_quaternion_unit_test: errors");
      $finish;
   end

   function automatic logic [31:0] pick_angle();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 8 << 20)) - (4 << 20));
         2: return 32'($signed($urandom_range(0, 720 << 20)) - (360 << 20));
         3: return {$urandom_range(0, 1) ? 12'hFFF : 12'h000, 20'($urandom())};
         4: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         default: return 32'($signed($urandom_range(0, 16)) - 8) <<< 20;
      endcase
   endfunction

   task automatic send_request(logic [31:0] r, logic [31:0] p, logic [31:0] y, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 16) : 0;
      repeat (gap) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_roll_angle <= r;
      req_pitch_angle <= p;
      req_yaw_angle <= y;
      @(posedge clock);
      while (busy) @(posedge clock);
      request_count++;
   endtask

   task automatic drain_and_set(logic deg);
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (45) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= deg;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   logic [31:0] edge_vals [10] = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF,
      32'h00000001, 32'h001921FB, 32'h003243F6, 32'h00B40000, 32'h05A00000, 32'hFF4C0000};

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int m = 0; m < 2; m++) begin
         drain_and_set(m[0]);
         for (int i = 0; i < 10; i++)
            send_request(edge_vals[i], edge_vals[(i + 3) % 10], edge_vals[(i + 7) % 10], 0);
      end
      for (int ph = 0; ph < 4; ph++) begin
         drain_and_set(ph[0] ^ 1'b1);
         for (int i = 0; i < 125; i++)
            send_request(pick_angle(), pick_angle(), pick_angle(), (i / 25) % 2 == 1);
      end
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (45) @(posedge clock);
      $display("%0d requests in both angle modes, %0d results compared", request_count,
               result_count);
      if (error_count == 0 && pending_count == 0)
         $display("euler_to_quaternion_unit_test: clean");
      else
         $display("euler_to_quaternion_unit_test: errors");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/e2q_pkg.sv
hw/rtl/e2q_lane.sv
hw/rtl/e2q_merge.sv
hw/rtl/euler_to_quaternion_unit.sv
tb/euler_to_quaternion_unit_checker.sv
tb/euler_to_quaternion_unit_test.sv
